// File: rtl/atan_waveshaper_blend_core_assert.svh
// Assertion macros used by the top level of the waveshaper RTL.
`ifndef ATAN_WAVESHAPER_BLEND_CORE_ASSERT_SVH
`define ATAN_WAVESHAPER_BLEND_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define AWB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("waveshaper assertion failed");

// Check cons in the cycle after ante.
`define AWB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("waveshaper assertion failed");

`endif

// File: rtl/awb_pkg.sv
// Types, constants and tables of the arctangent waveshaper.
package awb_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int ATAN_STEPS      = 16;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int STEPS = (ATAN_STEPS < ANGLE_TABLE_LEN) ? ATAN_STEPS : ANGLE_TABLE_LEN;
  localparam int ANG_IDX_W = $clog2(ANGLE_TABLE_LEN);

  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam int X23_W  = 24;
  localparam int NORM_W = SAMPLE_BITS + X23_W;
  localparam int P1_W   = X23_W + GAIN_W + 1;
  localparam int A_W    = P1_W + GAIN_W + 1;
  localparam int CW     = A_W + 2;
  localparam int CORDIC_ONE_POS = 42;
  localparam int ANG_W  = 32;
  localparam int Z_W    = ANG_W + 1;

  localparam int RECIP_W  = 24;
  localparam int ZB_W     = Z_W + GAIN_W + 1;
  localparam int XR_W     = SAMPLE_BITS + RECIP_W + 1;
  localparam int XR_SHIFT = 32 - SAMPLE_BITS;
  localparam int SUM_W    = XR_W + XR_SHIFT + 2;
  localparam int MIX_SHIFT = 16;
  localparam int RS_W     = SUM_W - MIX_SHIFT;
  localparam int PROD_W   = RS_W + GAIN_W + 1;
  localparam int OUT_SHIFT = 45 - SAMPLE_BITS;
  localparam int Y_W      = PROD_W - OUT_SHIFT;

  localparam int DIV_N_W   = 30;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(64'd1 << CORDIC_ONE_POS);
  localparam logic signed [SUM_W-1:0] MIX_HALF = SUM_W'(64'd1 << (MIX_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] OUT_HALF = PROD_W'(64'd1 << (OUT_SHIFT - 1));
  localparam logic [DIV_N_W-1:0] DIV_ONE = {1'b1, {(DIV_N_W-1){1'b0}}};

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [GAIN_W-1:0]  BLEND_ZERO_SUBST = 16'd33;
  localparam logic [GAIN_W-1:0]  DRIVE_RST  = 16'd32768;
  localparam logic [GAIN_W-1:0]  RANGE_RST  = 16'd16;
  localparam logic [GAIN_W-1:0]  BLEND_RST  = 16'd32768;
  localparam logic [GAIN_W-1:0]  VOLUME_RST = 16'd16384;
  localparam logic [RECIP_W-1:0] RECIP_RST  = 24'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE,
    CFG_RANGE,
    CFG_BLEND,
    CFG_VOLUME
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] drive_gain;
    logic [GAIN_W-1:0] range_gain;
    logic [GAIN_W-1:0] blend_gain;
    logic [GAIN_W-1:0] volume_gain;
  } gains_t;

  typedef struct packed {
    logic [RECIP_W-1:0] value;
    logic               busy;
  } recip_t;

  typedef struct packed {
    logic [CW-1:0]          cx;
    logic [CW-1:0]          cy;
    logic [Z_W-1:0]         z;
    logic [SAMPLE_BITS-1:0] x;
    logic                   neg;
    logic                   zero;
  } cordic_t;

  function automatic logic signed [X23_W-1:0] norm23(input logic signed [SAMPLE_BITS-1:0] x);
    logic signed [NORM_W-1:0] w;
    w = NORM_W'(x) <<< X23_W;
    w = w >>> SAMPLE_BITS;
    return w[X23_W-1:0];
  endfunction

  // atan(2^-i) with pi/2 = 2^30
  function automatic logic [ANG_W-1:0] angle(input logic [ANG_IDX_W-1:0] i);
    logic [ANG_W-1:0] a;
    case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/awb_recip.sv
// Bit-serial divider that computes the blend reciprocal on each blend write.
module awb_recip (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [awb_pkg::GAIN_W-1:0] blend_in,
  output awb_pkg::recip_t            recip
);
  import awb_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [GAIN_W-1:0]    b_r, b_nxt;
  logic [GAIN_W-1:0]    rem_r, rem_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [RECIP_W-1:0]   recip_r, recip_nxt;

  logic [GAIN_W-1:0]  beff;
  logic [GAIN_W:0]    trial;
  logic [GAIN_W:0]    diff;
  logic               take;
  logic [DIV_N_W-1:0] quo_step;

  always_comb begin
    beff     = (blend_in == '0) ? BLEND_ZERO_SUBST : blend_in;
    trial    = {rem_r, quo_r[DIV_N_W-1]};
    diff     = trial - {1'b0, b_r};
    take     = (trial >= {1'b0, b_r});
    quo_step = {quo_r[DIV_N_W-2:0], take};

    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    b_nxt     = b_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    recip_nxt = recip_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_N_W - 1);
      b_nxt    = beff;
      rem_nxt  = '0;
      quo_nxt  = DIV_ONE + DIV_N_W'(beff >> 1);
    end else if (busy_r) begin
      rem_nxt = take ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
      quo_nxt = quo_step;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt  = 1'b0;
        recip_nxt = (quo_step[DIV_N_W-1:RECIP_W] != '0) ? '1 : quo_step[RECIP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      recip_r <= RECIP_RST;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      recip_r <= recip_nxt;
    end
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign recip.value = recip_r;
  assign recip.busy  = busy_r;

endmodule

// File: rtl/awb_front.sv
// Drive and range scaling, then magnitude and sign split for the arctangent.
module awb_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [awb_pkg::SAMPLE_BITS-1:0] in_sample,
  input  awb_pkg::gains_t                 gains,
  output logic                            out_valid,
  input  logic                            out_ready,
  output awb_pkg::cordic_t                out_item
);
  import awb_pkg::*;

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic rdy1, rdy2, rdy3;

  logic signed [SAMPLE_BITS-1:0] x1_r, x1_nxt, x2_r, x2_nxt;
  logic signed [P1_W-1:0]        p1_r, p1_nxt;
  logic signed [A_W-1:0]         a_r, a_nxt;
  cordic_t                       c_r, c_nxt;

  logic signed [X23_W-1:0] x23;
  logic                    a_neg;
  logic [A_W-1:0]          a_mag;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;

    x23   = norm23($signed(in_sample));
    a_neg = a_r[A_W-1];
    a_mag = a_neg ? (~a_r + 1'b1) : a_r;

    x1_nxt = x1_r;
    p1_nxt = p1_r;
    if (rdy1 && in_valid) begin
      x1_nxt = $signed(in_sample);
      p1_nxt = x23 * $signed({1'b0, gains.drive_gain});
    end

    x2_nxt = x2_r;
    a_nxt  = a_r;
    if (rdy2 && v1_r) begin
      x2_nxt = x1_r;
      a_nxt  = p1_r * $signed({1'b0, gains.range_gain});
    end

    c_nxt = c_r;
    if (rdy3 && v2_r) begin
      c_nxt.cx   = CORDIC_X0;
      c_nxt.cy   = {2'b00, a_mag};
      c_nxt.z    = '0;
      c_nxt.x    = x2_r;
      c_nxt.neg  = a_neg;
      c_nxt.zero = (a_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
    x1_r <= x1_nxt;
    p1_r <= p1_nxt;
    x2_r <= x2_nxt;
    a_r  <= a_nxt;
    c_r  <= c_nxt;
  end

  assign out_valid = v3_r;
  assign out_item  = c_r;

endmodule

// File: rtl/awb_cordic.sv
// Vectoring CORDIC arctangent, one iteration per pipeline stage.
module awb_cordic (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  awb_pkg::cordic_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output awb_pkg::cordic_t out_item
);
  import awb_pkg::*;

  logic    v_r   [STEPS];
  logic    v_nxt [STEPS];
  logic    rdy   [STEPS];
  cordic_t st_r  [STEPS];
  cordic_t st_nxt[STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    cordic_t src;
    cordic_t res;
    logic    src_v;
    logic    dn_rdy;

    if (i == 0) begin : g_first
      assign src   = in_item;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = st_r[i-1];
      assign src_v = v_r[i-1];
    end

    if (i == STEPS - 1) begin : g_last
      assign dn_rdy = out_ready;
    end else begin : g_mid
      assign dn_rdy = rdy[i+1];
    end

    assign rdy[i] = !v_r[i] || dn_rdy;

    always_comb begin
      res = src;
      if ($signed(src.cy) >= 0) begin
        res.cx = $signed(src.cx) + ($signed(src.cy) >>> i);
        res.cy = $signed(src.cy) - ($signed(src.cx) >>> i);
        res.z  = $signed(src.z) + $signed(Z_W'(angle(ANG_IDX_W'(i))));
      end else begin
        res.cx = $signed(src.cx) - ($signed(src.cy) >>> i);
        res.cy = $signed(src.cy) + ($signed(src.cx) >>> i);
        res.z  = $signed(src.z) - $signed(Z_W'(angle(ANG_IDX_W'(i))));
      end
    end

    assign st_nxt[i] = (rdy[i] && src_v) ? res : st_r[i];
    assign v_nxt[i]  = rdy[i] ? src_v : v_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '{default: 1'b0};
    end else begin
      v_r <= v_nxt;
    end
    st_r <= st_nxt;
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[STEPS-1];
  assign out_item  = st_r[STEPS-1];

endmodule

// File: rtl/awb_mix.sv
// Blend of shaped and clean sample, volume scaling and saturation.
module awb_mix (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  awb_pkg::cordic_t                 in_item,
  input  awb_pkg::gains_t                  gains,
  input  logic [awb_pkg::RECIP_W-1:0]      recip_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [awb_pkg::SAMPLE_BITS-1:0]  out_sample,
  output logic                             out_clipped
);
  import awb_pkg::*;

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, v4_r, v4_nxt, v5_r, v5_nxt;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic signed [Z_W-1:0]         z1_r, z1_nxt;
  logic signed [SAMPLE_BITS-1:0] x1_r, x1_nxt;
  logic signed [ZB_W-1:0]        zb2_r, zb2_nxt;
  logic signed [XR_W-1:0]        xr2_r, xr2_nxt;
  logic signed [RS_W-1:0]        rs3_r, rs3_nxt;
  logic signed [PROD_W-1:0]      prod4_r, prod4_nxt;
  logic signed [SAMPLE_BITS-1:0] y5_r, y5_nxt;
  logic                          clip5_r, clip5_nxt;

  logic signed [Z_W-1:0]    z_in;
  logic signed [Z_W-1:0]    z_sgn;
  logic [GAIN_W-1:0]        beff;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_rnd;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [Y_W-1:0]    y_full;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
    v4_nxt = rdy4 ? v3_r : v4_r;
    v5_nxt = rdy5 ? v4_r : v5_r;

    z_in  = $signed(in_item.z);
    z_sgn = in_item.zero ? '0 : (in_item.neg ? -z_in : z_in);
    beff  = (gains.blend_gain == '0) ? BLEND_ZERO_SUBST : gains.blend_gain;

    sum     = SUM_W'(zb2_r) + (SUM_W'(xr2_r) <<< XR_SHIFT);
    sum_rnd = sum + MIX_HALF;

    prod_rnd = prod4_r + OUT_HALF;
    y_full   = Y_W'(prod_rnd >>> OUT_SHIFT);

    z1_nxt = z1_r;
    x1_nxt = x1_r;
    if (rdy1 && in_valid) begin
      z1_nxt = z_sgn;
      x1_nxt = $signed(in_item.x);
    end

    zb2_nxt = zb2_r;
    xr2_nxt = xr2_r;
    if (rdy2 && v1_r) begin
      zb2_nxt = z1_r * $signed({1'b0, beff});
      xr2_nxt = x1_r * $signed({1'b0, recip_value});
    end

    rs3_nxt = rs3_r;
    if (rdy3 && v2_r) begin
      rs3_nxt = RS_W'(sum_rnd >>> MIX_SHIFT);
    end

    prod4_nxt = prod4_r;
    if (rdy4 && v3_r) begin
      prod4_nxt = rs3_r * $signed({1'b0, gains.volume_gain});
    end

    y5_nxt    = y5_r;
    clip5_nxt = clip5_r;
    if (rdy5 && v4_r) begin
      if (y_full > Y_W'(SAMPLE_MAX)) begin
        y5_nxt    = SAMPLE_MAX;
        clip5_nxt = 1'b1;
      end else if (y_full < Y_W'(SAMPLE_MIN)) begin
        y5_nxt    = SAMPLE_MIN;
        clip5_nxt = 1'b1;
      end else begin
        y5_nxt    = y_full[SAMPLE_BITS-1:0];
        clip5_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
      v5_r <= v5_nxt;
    end
    z1_r    <= z1_nxt;
    x1_r    <= x1_nxt;
    zb2_r   <= zb2_nxt;
    xr2_r   <= xr2_nxt;
    rs3_r   <= rs3_nxt;
    prod4_r <= prod4_nxt;
    y5_r    <= y5_nxt;
    clip5_r <= clip5_nxt;
  end

  assign out_valid   = v5_r;
  assign out_sample  = y5_r;
  assign out_clipped = clip5_r;

endmodule

// File: rtl/atan_waveshaper_blend_core.sv
// Top level of the arctangent soft-clip waveshaper with dry/wet blend.
// Pipeline stages: 3 scaling, 16 CORDIC, 5 mix.
// Throughput: one item per cycle while the divider is idle; stages fill bubbles while the output is stalled.
// A blend register write runs a 30-step serial divider; input ready is low while the divider is busy.
// Reset (rst_n low, synchronous): pipeline emptied, registers to defaults, reciprocal 16384.
module atan_waveshaper_blend_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [awb_pkg::SAMPLE_BITS-1:0]    in_sample_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [awb_pkg::SAMPLE_BITS-1:0]    out_sample_out,
  output logic                               out_clipped,
  input  logic                               cfg_we,
  input  logic [awb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [awb_pkg::GAIN_W-1:0]         cfg_data
);
  import awb_pkg::*;

  `include "atan_waveshaper_blend_core_assert.svh"

  logic [GAIN_W-1:0] drive_r, drive_nxt;
  logic [GAIN_W-1:0] range_r, range_nxt;
  logic [GAIN_W-1:0] blend_r, blend_nxt;
  logic [GAIN_W-1:0] volume_r, volume_nxt;

  gains_t  gains;
  recip_t  recip;
  logic    blend_wr;
  logic    front_valid, front_ready;
  cordic_t front_item;
  logic    cordic_valid, cordic_ready;
  cordic_t cordic_item;
  logic    mix_ready;
  logic    front_in_ready;

  always_comb begin
    drive_nxt  = drive_r;
    range_nxt  = range_r;
    blend_nxt  = blend_r;
    volume_nxt = volume_r;
    blend_wr   = 1'b0;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DRIVE:  drive_nxt = cfg_data;
        CFG_RANGE:  range_nxt = cfg_data;
        CFG_BLEND: begin
          blend_nxt = cfg_data;
          blend_wr  = 1'b1;
        end
        CFG_VOLUME: volume_nxt = cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r  <= DRIVE_RST;
      range_r  <= RANGE_RST;
      blend_r  <= BLEND_RST;
      volume_r <= VOLUME_RST;
    end else begin
      drive_r  <= drive_nxt;
      range_r  <= range_nxt;
      blend_r  <= blend_nxt;
      volume_r <= volume_nxt;
    end
  end

  assign gains.drive_gain  = drive_r;
  assign gains.range_gain  = range_r;
  assign gains.blend_gain  = blend_r;
  assign gains.volume_gain = volume_r;

  awb_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (blend_wr),
    .blend_in (cfg_data),
    .recip    (recip)
  );

  assign in_ready = front_in_ready && !recip.busy;

  awb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid && !recip.busy),
    .in_ready  (front_in_ready),
    .in_sample (in_sample_in),
    .gains     (gains),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_item  (front_item)
  );

  awb_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (cordic_valid),
    .out_ready (cordic_ready),
    .out_item  (cordic_item)
  );

  assign cordic_ready = mix_ready;

  awb_mix u_mix (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cordic_valid),
    .in_ready    (mix_ready),
    .in_item     (cordic_item),
    .gains       (gains),
    .recip_value (recip.value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample_out),
    .out_clipped (out_clipped)
  );

  `AWB_ASSERT_SAME(a_div_blocks_input, recip.busy, !in_ready)
  `AWB_ASSERT_NEXT(a_blend_write_starts_div, cfg_we && (cfg_index == CFG_BLEND), recip.busy)
  `AWB_ASSERT_SAME(a_clip_at_full_scale, out_valid && out_clipped, (out_sample_out == SAMPLE_MAX) || (out_sample_out == SAMPLE_MIN))
  `AWB_ASSERT_SAME(a_recip_nonzero, 1'b1, recip.value != '0)

endmodule

// File: verif/atan_waveshaper_blend_core_test.sv
// Self-checking bench for the arctangent waveshaper: register sweeps, random samples, exact prediction.
module atan_waveshaper_blend_core_test;
  import awb_pkg::*;

  localparam int SB            = SAMPLE_BITS;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_ITEMS   = 130;
  localparam int RANDOM_PHASES = 12;
  localparam int MAX_PRINTED   = 40;
  localparam int TABLE_LEN     = 24;
  localparam longint ZERO_BLEND = 33;
  localparam longint RECIP_SAT  = 64'hFFFFFF;
  localparam longint OUT_MAX    = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint OUT_MIN    = -OUT_MAX - 1;
  localparam logic [SB-1:0] FULL_POS = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] FULL_NEG = {1'b1, {(SB-1){1'b0}}};

  typedef struct packed {
    logic [SB-1:0] sample;
    logic          clipped;
  } shaped_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [SB-1:0]     in_sample_in = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [SB-1:0]     out_sample_out;
  logic              out_clipped;
  logic              cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data     = '0;

  // predictor copy of the registers and the blend reciprocal
  logic [GAIN_W-1:0] cur_drive  = 16'd32768;
  logic [GAIN_W-1:0] cur_range  = 16'd16;
  logic [GAIN_W-1:0] cur_blend  = 16'd32768;
  logic [GAIN_W-1:0] cur_volume = 16'd16384;
  logic [23:0]       cur_recip  = 24'd16384;

  longint angle_q30 [TABLE_LEN] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic [SB-1:0] pending_samples [$];
  shaped_t       shaped_expected [$];
  shaped_t       oldest;

  int in_gap_max      = 0;
  int out_gap_max     = 0;
  int in_wait         = 0;
  int out_wait        = 0;
  int items_accepted  = 0;
  int results_checked = 0;
  int clipped_seen    = 0;
  int mismatches      = 0;
  int settings_used   = 0;
  int writes_done     = 0;
  int idle_cycles     = 0;

  atan_waveshaper_blend_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [23:0] reciprocal_of(input logic [GAIN_W-1:0] blend);
    longint b;
    longint r;
    b = (blend == 0) ? ZERO_BLEND : longint'(blend);
    r = ((64'sd1 <<< 29) + (b >>> 1)) / b;
    return (r > RECIP_SAT) ? 24'hFFFFFF : 24'(r);
  endfunction

  function automatic shaped_t shape_sample(input logic [SB-1:0] smp);
    longint x, x23, arg, cx, cy, cz, xs, ys, b, sum, prod, y;
    int i;
    shaped_t r;
    x = longint'($signed(smp));
    if (SB >= 24) begin
      x23 = x >>> (SB - 24);
    end else begin
      x23 = x <<< (24 - SB);
    end
    arg = x23 * longint'(cur_drive) * longint'(cur_range);
    cz = 0;
    if (arg != 0) begin
      cx = 64'sd1 <<< 42;
      cy = (arg < 0) ? -arg : arg;
      for (i = 0; i < ATAN_STEPS && i < TABLE_LEN; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (cy >= 0) begin
          cx = cx + ys;
          cy = cy - xs;
          cz = cz + angle_q30[i];
        end else begin
          cx = cx - ys;
          cy = cy + xs;
          cz = cz - angle_q30[i];
        end
      end
      if (arg < 0) begin
        cz = -cz;
      end
    end
    b = (cur_blend == 0) ? ZERO_BLEND : longint'(cur_blend);
    sum = cz * b + x * longint'(cur_recip) * (64'sd1 <<< (32 - SB));
    prod = ((sum + (64'sd1 <<< 15)) >>> 16) * longint'(cur_volume);
    y = (prod + (64'sd1 <<< (44 - SB))) >>> (45 - SB);
    r.clipped = 1'b0;
    if (y > OUT_MAX) begin
      y = OUT_MAX;
      r.clipped = 1'b1;
    end
    if (y < OUT_MIN) begin
      y = OUT_MIN;
      r.clipped = 1'b1;
    end
    r.sample = SB'(y);
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain(input logic [GAIN_W-1:0] top);
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return top;
      2:       return '1;
      3:       return GAIN_W'($urandom_range(1, 64));
      default: return GAIN_W'($urandom_range(0, top));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("mismatch at result %0d: %s", results_checked, msg);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [GAIN_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_DRIVE:  cur_drive = val;
      CFG_RANGE:  cur_range = val;
      CFG_BLEND: begin
        cur_blend = val;
        cur_recip = reciprocal_of(val);
      end
      CFG_VOLUME: cur_volume = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    writes_done++;
  endtask

  // wait until every item is through, then let the pipeline run dry
  task automatic settle();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || shaped_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        shaped_expected.push_back(shape_sample(in_sample_in));
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_valid     <= 1'b1;
          in_sample_in <= pending_samples.pop_front();
          in_wait = $urandom_range(0, in_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (shaped_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected item, sample %0d", $signed(out_sample_out)));
        end else begin
          oldest = shaped_expected.pop_front();
          if (out_sample_out !== oldest.sample) begin
            report_mismatch($sformatf("sample_out %0d, want %0d",
                                      $signed(out_sample_out), $signed(oldest.sample)));
          end
          if (out_clipped !== oldest.clipped) begin
            report_mismatch($sformatf("clipped %b, want %b", out_clipped, oldest.clipped));
          end
          if (oldest.clipped) begin
            clipped_seen++;
          end
        end
        out_wait = $urandom_range(0, out_gap_max);
      end
      if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no progress for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic signed [SB-1:0] smp;
    int k;
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, back to back
    settings_used++;
    pending_samples.push_back('0);
    pending_samples.push_back(SB'(1));
    pending_samples.push_back(SB'(-1));
    pending_samples.push_back(FULL_POS);
    pending_samples.push_back(FULL_NEG);
    pending_samples.push_back(SB'(24'h400000));
    pending_samples.push_back(SB'(-4194304));
    pending_samples.push_back(SB'(24'h123456));
    settle();

    // zero blend with volume above range: saturation both ways
    in_gap_max  = 7;
    out_gap_max = 7;
    write_reg(CFG_VOLUME, 16'hFFFF);
    write_reg(CFG_BLEND, 16'd0);
    settings_used++;
    pending_samples.push_back(FULL_POS);
    pending_samples.push_back(FULL_NEG);
    pending_samples.push_back(SB'(1000));
    pending_samples.push_back(SB'(-1000));
    pending_samples.push_back('0);
    settle();

    // zero drive gives a zero arctangent; tiny blend saturates the reciprocal
    write_reg(CFG_DRIVE, 16'd0);
    write_reg(CFG_BLEND, 16'd1);
    settings_used++;
    pending_samples.push_back(FULL_POS);
    pending_samples.push_back(SB'(-5));
    pending_samples.push_back(SB'(24'h2AAAAA));
    pending_samples.push_back(SB'(24'h555555));
    settle();

    // drive, range and blend at their top code, volume muted
    write_reg(CFG_DRIVE, 16'hFFFF);
    write_reg(CFG_RANGE, 16'hFFFF);
    write_reg(CFG_VOLUME, 16'd0);
    write_reg(CFG_BLEND, 16'hFFFF);
    settings_used++;
    pending_samples.push_back(FULL_POS);
    pending_samples.push_back(FULL_NEG);
    pending_samples.push_back(SB'(3));
    pending_samples.push_back(SB'(-3));
    settle();

    // nominal maxima
    write_reg(CFG_DRIVE, 16'd32768);
    write_reg(CFG_RANGE, 16'd48000);
    write_reg(CFG_VOLUME, 16'd49152);
    write_reg(CFG_BLEND, 16'd32768);
    settings_used++;
    pending_samples.push_back(FULL_POS);
    pending_samples.push_back(FULL_NEG);
    pending_samples.push_back(SB'(12345));
    settle();

    for (k = 0; k < RANDOM_PHASES; k++) begin
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 7;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      if ($urandom_range(0, 3) != 0) write_reg(CFG_DRIVE, pick_gain(16'd32768));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_RANGE, pick_gain(16'd48000));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_VOLUME, pick_gain(16'd49152));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_BLEND, pick_gain(16'd32768));
      settings_used++;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 5))
          0: smp = FULL_POS - SB'($urandom_range(0, 3));
          1: smp = FULL_NEG + SB'($urandom_range(0, 3));
          2, 3: begin
            smp = SB'($urandom);
            smp = smp >>> $urandom_range(0, SB - 1);
          end
          default: smp = SB'($urandom);
        endcase
        pending_samples.push_back(smp);
      end
      settle();
    end

    $display("%0d samples checked over %0d register settings (%0d writes)",
             results_checked, settings_used, writes_done);
    $display("%0d results saturated, %0d mismatches", clipped_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: atan_waveshaper_blend_core.f
+incdir+rtl
rtl/awb_pkg.sv
rtl/awb_recip.sv
rtl/awb_front.sv
rtl/awb_cordic.sv
rtl/awb_mix.sv
rtl/atan_waveshaper_blend_core.sv
verif/atan_waveshaper_blend_core_test.sv
